### hdl/distance_window_settle_and_jump_detect_assert.svh
// assertion macros for the distance window settle and jump detector
// no dependencies; define NO_ASSERTIONS to compile the checks out
`ifndef DISTANCE_WINDOW_SETTLE_AND_JUMP_DETECT_ASSERT_SVH
`define DISTANCE_WINDOW_SETTLE_AND_JUMP_DETECT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked outside reset
`define DWSJ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dwsj assertion failed");

// next-cycle implication, checked outside reset
`define DWSJ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dwsj assertion failed");

`else

`define DWSJ_ASSERT_NOW(label, clk, rst, ante, cons)
`define DWSJ_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### hdl/dwsj_pkg.sv
// shared types and constants of the distance window settle and jump detector
// no dependencies; used by dwsj_alu and the top level
package dwsj_pkg;

   // field widths
   localparam int DIST_W     = 10;
   localparam int TOL_W      = 8;
   localparam int AGREE_W    = 5;
   localparam int CSR_DATA_W = 8;
   localparam int CSR_IDX_W  = 1;

   // samples per window, a power of two so the mean is a plain shift of the sum
   localparam int WINDOW = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_TOLERANCE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_AGREE = 1'b1;

   // register reset values
   localparam logic [TOL_W-1:0]   TOL_RESET   = 8'd5;
   localparam logic [AGREE_W-1:0] AGREE_RESET = 5'd8;

endpackage

### hdl/dwsj_alu.sv
// shared compare unit: one open-band check of a stored sample per cycle
// depends on dwsj_pkg
module dwsj_alu (
   input  logic [dwsj_pkg::DIST_W-1:0]    sample,
   input  logic [dwsj_pkg::DIST_W-1:0]    center,
   input  logic [dwsj_pkg::TOL_W-1:0]     tol,
   output logic                           hit
);

   logic [dwsj_pkg::DIST_W:0]     sample_hi;
   logic [dwsj_pkg::DIST_W:0]     center_hi;

   // open band: center - tol < sample < center + tol, kept unsigned
   assign sample_hi = {1'b0, sample} + (dwsj_pkg::DIST_W + 1)'(tol);
   assign center_hi = {1'b0, center} + (dwsj_pkg::DIST_W + 1)'(tol);
   assign hit       = (sample_hi > {1'b0, center}) && ({1'b0, sample} < center_hi);

endmodule

### hdl/distance_window_settle_and_jump_detect.sv
// top level of the distance window settle and jump detector
// depends on dwsj_pkg, dwsj_alu and distance_window_settle_and_jump_detect_assert.svh
//
// channel   direction  handshake              payload
// req       in         req_tvalid/req_tready  req_tdata: distance
// rsp       out        rsp_tvalid/rsp_tready  rsp_tdata: settled, reference_out, jump, monitoring
// csr       in         csr_valid/csr_ready    csr_index, csr_wdata (taken only while idle)
//
// a request that does not close a window loads its response at the accepting edge
// a window close takes the mean as a shift of the sum at the accepting edge (the reference
// once monitoring), then, settling or not, primes the sample memory read port, runs WINDOW
// band checks on the shared unit and loads the response once the output register is free
// synchronous active-high reset; no request is taken while a window is judged
// or while an undelivered response blocks the output register
`include "distance_window_settle_and_jump_detect_assert.svh"

module distance_window_settle_and_jump_detect (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,    // [9:0] distance, [15:10] zero
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // [0] settled, [10:1] reference_out, [11] jump,
                                     // [12] monitoring, [15:13] zero
   // register write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [dwsj_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dwsj_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int WINDOW = dwsj_pkg::WINDOW;
   localparam int IDX_W  = $clog2(WINDOW);
   localparam int SUM_W  = dwsj_pkg::DIST_W + IDX_W;
   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int CMP_W  = (CNT_W > dwsj_pkg::AGREE_W) ? CNT_W : dwsj_pkg::AGREE_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_RD,
      S_CMP,
      S_DONE
   } state_type;

   state_type                         state_ff, state_in;
   logic                              phase_ff, phase_in;
   logic [IDX_W-1:0]                  fill_ff, fill_in;
   logic [SUM_W-1:0]                  sum_ff, sum_in;
   logic [dwsj_pkg::DIST_W-1:0]       ref_ff, ref_in;
   logic [dwsj_pkg::TOL_W-1:0]        tol_ff, tol_in;
   logic [dwsj_pkg::AGREE_W-1:0]      agree_ff, agree_in;
   logic [dwsj_pkg::DIST_W-1:0]       center_ff, center_in;
   logic [CNT_W-1:0]                  cnt_ff, cnt_in;
   logic [IDX_W-1:0]                  rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]                  cmp_idx_ff, cmp_idx_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_settled_ff, rsp_settled_in;
   logic [dwsj_pkg::DIST_W-1:0]       rsp_ref_ff, rsp_ref_in;
   logic                              rsp_jump_ff, rsp_jump_in;
   logic                              rsp_mon_ff, rsp_mon_in;

   logic [dwsj_pkg::DIST_W-1:0]       mem [WINDOW];
   logic [dwsj_pkg::DIST_W-1:0]       rd_data_ff;

   logic [dwsj_pkg::DIST_W-1:0]       distance;
   logic                              req_take;
   logic                              out_free;
   logic                              win_last;
   logic                              settle_ok;
   logic [SUM_W-1:0]                  win_total;
   logic                              alu_hit;

   assign distance   = req_tdata[dwsj_pkg::DIST_W-1:0];
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign req_take   = req_tvalid && req_tready;
   assign win_last   = (fill_ff == IDX_W'(WINDOW - 1));
   assign csr_ready  = (state_ff == S_IDLE);
   assign win_total  = sum_ff + SUM_W'(distance);

   // response port
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_mon_ff, rsp_jump_ff, rsp_ref_ff, rsp_settled_ff};

   // sample memory: written on each request, read one entry a cycle when judging
   always_ff @(posedge clock) begin
      if (req_take) begin
         mem[fill_ff] <= distance;
      end
      rd_data_ff <= mem[rd_idx_ff];
   end

   // shared unit: one band check a cycle
   dwsj_alu u_alu (
      .sample (rd_data_ff),
      .center (center_ff),
      .tol    (tol_ff),
      .hit    (alu_hit)
   );

   // settling verdict: non-zero mean and every sample in band
   assign settle_ok = (center_ff != '0) && (cnt_ff == CNT_W'(WINDOW));

   // sequencer next state
   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      fill_in        = fill_ff;
      sum_in         = sum_ff;
      ref_in         = ref_ff;
      tol_in         = tol_ff;
      agree_in       = agree_ff;
      center_in      = center_ff;
      cnt_in         = cnt_ff;
      rd_idx_in      = rd_idx_ff;
      cmp_idx_in     = cmp_idx_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_settled_in = rsp_settled_ff;
      rsp_ref_in     = rsp_ref_ff;
      rsp_jump_in    = rsp_jump_ff;
      rsp_mon_in     = rsp_mon_ff;

      // register writes
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            dwsj_pkg::REG_TOLERANCE: tol_in   = csr_wdata[dwsj_pkg::TOL_W-1:0];
            dwsj_pkg::REG_MIN_AGREE: agree_in = csr_wdata[dwsj_pkg::AGREE_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               fill_in = win_last ? '0 : fill_ff + IDX_W'(1);
               if (!phase_ff) begin
                  if (win_last) begin
                     // window full: the mean is the sum shifted down by log2 of the window length
                     sum_in    = '0;
                     center_in = win_total[SUM_W-1:IDX_W];
                     rd_idx_in = '0;
                     state_in  = S_RD;
                  end else begin
                     sum_in         = win_total;
                     rsp_valid_in   = 1'b1;
                     rsp_settled_in = 1'b0;
                     rsp_ref_in     = ref_ff;
                     rsp_jump_in    = 1'b0;
                     rsp_mon_in     = 1'b0;
                  end
               end else begin
                  if (win_last) begin
                     center_in = ref_ff;
                     rd_idx_in = '0;
                     state_in  = S_RD;
                  end else begin
                     rsp_valid_in   = 1'b1;
                     rsp_settled_in = 1'b0;
                     rsp_ref_in     = ref_ff;
                     rsp_jump_in    = 1'b0;
                     rsp_mon_in     = 1'b1;
                  end
               end
            end
         end
         S_RD: begin
            // first entry is on its way out of the memory
            rd_idx_in  = IDX_W'(1);
            cmp_idx_in = '0;
            cnt_in     = '0;
            state_in   = S_CMP;
         end
         S_CMP: begin
            // count in-band samples, one entry a cycle
            cnt_in    = cnt_ff + CNT_W'(alu_hit);
            rd_idx_in = (rd_idx_ff == IDX_W'(WINDOW - 1)) ? '0 : rd_idx_ff + IDX_W'(1);
            if (cmp_idx_ff == IDX_W'(WINDOW - 1)) begin
               state_in = S_DONE;
            end else begin
               cmp_idx_in = cmp_idx_ff + IDX_W'(1);
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_settled_in = 1'b0;
               rsp_jump_in    = 1'b0;
               rsp_ref_in     = ref_ff;
               rsp_mon_in     = phase_ff;
               if (!phase_ff) begin
                  if (settle_ok) begin
                     ref_in         = center_ff;
                     phase_in       = 1'b1;
                     rsp_settled_in = 1'b1;
                     rsp_ref_in     = center_ff;
                     rsp_mon_in     = 1'b1;
                  end
               end else begin
                  rsp_jump_in = CMP_W'(cnt_ff) < CMP_W'(agree_ff);
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= 1'b0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         ref_ff       <= '0;
         tol_ff       <= dwsj_pkg::TOL_RESET;
         agree_ff     <= dwsj_pkg::AGREE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         ref_ff       <= ref_in;
         tol_ff       <= tol_in;
         agree_ff     <= agree_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      center_ff      <= center_in;
      cnt_ff         <= cnt_in;
      rd_idx_ff      <= rd_idx_in;
      cmp_idx_ff     <= cmp_idx_in;
      rsp_settled_ff <= rsp_settled_in;
      rsp_ref_ff     <= rsp_ref_in;
      rsp_jump_ff    <= rsp_jump_in;
      rsp_mon_ff     <= rsp_mon_in;
   end

   // checks
   `DWSJ_ASSERT_NEXT(a_phase_sticky, clock, reset, phase_ff, phase_ff)
   `DWSJ_ASSERT_NOW(a_sum_idle_in_monitor, clock, reset, phase_ff, sum_ff == '0)
   `DWSJ_ASSERT_NOW(a_settle_has_reference, clock, reset, rsp_valid_ff && rsp_settled_ff,
                    (rsp_ref_ff != '0) && rsp_mon_ff)
   `DWSJ_ASSERT_NOW(a_jump_only_monitoring, clock, reset, rsp_valid_ff && rsp_jump_ff,
                    rsp_mon_ff && !rsp_settled_ff)
   `DWSJ_ASSERT_NOW(a_reference_before_monitor, clock, reset, !phase_ff, ref_ff == '0)

endmodule
